@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while in reset
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define DEQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/deq_pkg.sv @@
package deq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REV    = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_PREV,
    SEL_NEXT,
    SEL_LOAD
  } cell_sel_t;

endpackage

@@ src/deq_if.sv @@
interface deq_in_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic                 at_back;
  logic [WORD_BITS-1:0] data_in;
  logic [WORD_BITS-1:0] search_key;

  modport source (output valid, op, at_back, data_in, search_key, input ready);
  modport sink   (input valid, op, at_back, data_in, search_key, output ready);
endinterface

interface deq_out_if #(
  parameter int WORD_BITS = 32,
  parameter int CNT_BITS  = 5
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] data_out;
  logic [1:0]           status;
  logic [CNT_BITS-1:0]  entry_count;

  modport source (output valid, data_out, status, entry_count, input ready);
  modport sink   (input valid, data_out, status, entry_count, output ready);
endinterface

@@ src/double_ended_queue_with_search_unit.sv @@
// Push, front pop, reverse and any item on an empty queue go straight to ST_DONE.
// Back pop and search of a non-empty queue pass through ST_WALK, where the cell ring rotates
// once around so a compare point at one chain end (chosen by direction) sees every entry in order.
// Result passes from ST_DONE into the output register once that is free; the next item is taken while it waits there.
// Reset (rst_n low, synchronous): queue empty, not reversed, no result pending.
`include "assert_macros.svh"

module double_ended_queue_with_search_unit
  import deq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  deq_in_if.sink       in_ch,
  deq_out_if.source    out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int RB = $clog2(DEPTH);
  localparam logic [CW:0]   DEPTH_W = (CW+1)'(DEPTH);
  localparam logic [RB-1:0] R_LAST  = RB'(DEPTH - 1);

  logic [WORD_BITS-1:0] q   [DEPTH];
  cell_sel_t            sel [DEPTH];

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 rev_r, rev_nxt;
  logic [RB-1:0]        rot_r, rot_nxt;
  logic                 dir_r, dir_nxt;
  logic                 pop_r, pop_nxt;
  logic                 found_r, found_nxt;
  logic [WORD_BITS-1:0] key_r, key_nxt;
  logic [WORD_BITS-1:0] res_data_r, res_data_nxt;
  status_t              res_stat_r, res_stat_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_data_r, out_data_nxt;
  status_t              out_stat_r, out_stat_nxt;
  logic [CW-1:0]        out_cnt_r, out_cnt_nxt;

  logic acc;
  logic stored_back;
  logic full;
  logic empty;
  op_t  op;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk    (clk),
      .sel    (sel[i]),
      .prev_i (q[(i + DEPTH - 1) % DEPTH]),
      .next_i (q[(i + 1) % DEPTH]),
      .load_i (in_ch.data_in),
      .q_o    (q[i])
    );
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign op          = op_t'(in_ch.op);
  assign stored_back = in_ch.at_back ^ rev_r;
  assign full        = (cnt_r == CW'(DEPTH));
  assign empty       = (cnt_r == '0);

  always_comb begin
    logic [CW:0] rsum;
    logic        hit;
    rsum          = (CW+1)'(rot_r) + (CW+1)'(cnt_r);
    hit           = 1'b0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rev_nxt       = rev_r;
    rot_nxt       = rot_r;
    dir_nxt       = dir_r;
    pop_nxt       = pop_r;
    found_nxt     = found_r;
    key_nxt       = key_r;
    res_data_nxt  = res_data_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    for (int i = 0; i < DEPTH; i++) begin
      sel[i] = SEL_HOLD;
    end

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          res_data_nxt = '0;
          res_stat_nxt = STAT_OK;
          state_nxt    = ST_DONE;
          case (op)
            OP_PUSH: begin
              if (full) begin
                res_stat_nxt = STAT_FULL;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
                if (stored_back) begin
                  for (int i = 0; i < DEPTH; i++) begin
                    if (CW'(i) == cnt_r) sel[i] = SEL_LOAD;
                  end
                end else begin
                  for (int i = 1; i < DEPTH; i++) begin
                    sel[i] = SEL_PREV;
                  end
                  sel[0] = SEL_LOAD;
                end
              end
            end
            OP_POP: begin
              if (empty) begin
                res_stat_nxt = STAT_EMPTY;
              end else if (stored_back) begin
                state_nxt = ST_WALK;
                rot_nxt   = '0;
                dir_nxt   = 1'b0;
                pop_nxt   = 1'b1;
              end else begin
                res_data_nxt = q[0];
                cnt_nxt      = cnt_r - 1'b1;
                for (int i = 0; i < DEPTH; i++) begin
                  sel[i] = SEL_NEXT;
                end
              end
            end
            OP_REV: begin
              rev_nxt = !rev_r;
            end
            OP_SEARCH: begin
              if (empty) begin
                res_stat_nxt = STAT_EMPTY;
              end else begin
                state_nxt    = ST_WALK;
                rot_nxt      = '0;
                dir_nxt      = rev_r;
                pop_nxt      = 1'b0;
                found_nxt    = 1'b0;
                key_nxt      = in_ch.search_key;
                res_stat_nxt = STAT_NOT_FOUND;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_WALK: begin
        for (int i = 0; i < DEPTH; i++) begin
          sel[i] = dir_r ? SEL_PREV : SEL_NEXT;
        end
        if (pop_r) begin
          if ((CW+1)'(rot_r) + 1'b1 == (CW+1)'(cnt_r)) res_data_nxt = q[0];
        end else if (!found_r) begin
          if (dir_r) hit = (q[DEPTH-1] == key_r) && (rsum >= DEPTH_W);
          else       hit = (q[0] == key_r) && (CW'(rot_r) < cnt_r);
          if (hit) begin
            found_nxt    = 1'b1;
            res_data_nxt = key_r;
            res_stat_nxt = STAT_OK;
          end
        end
        rot_nxt = rot_r + 1'b1;
        if (rot_r == R_LAST) begin
          state_nxt = ST_DONE;
          if (pop_r) cnt_nxt = cnt_r - 1'b1;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_stat_nxt  = res_stat_r;
          out_cnt_nxt   = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rot_r      <= rot_nxt;
    dir_r      <= dir_nxt;
    pop_r      <= pop_nxt;
    found_r    <= found_nxt;
    key_r      <= key_nxt;
    res_data_r <= res_data_nxt;
    res_stat_r <= res_stat_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_out    = out_data_r;
  assign out_ch.status      = out_stat_r;
  assign out_ch.entry_count = out_cnt_r;

  `DEQ_ASSERT_RST(a_reset_empty, !rst_n |=> (cnt_r == '0) && (state_r == ST_IDLE), "reset not empty")
  `DEQ_ASSERT(a_cnt_bound, cnt_r <= CW'(DEPTH), "count above depth")
  `DEQ_ASSERT(a_accept_busy, acc |=> state_r != ST_IDLE, "item accepted but not worked")
  `DEQ_ASSERT(a_walk_end, (state_r == ST_WALK) && (rot_r == R_LAST) |=> state_r == ST_DONE, "walk overran ring")
  `DEQ_ASSERT(a_full_drop, acc && (op == OP_PUSH) && full |=> $stable(cnt_r), "push taken while full")

endmodule

@@ src/deq_cell.sv @@
module deq_cell
  import deq_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  cell_sel_t            sel,
  input  logic [WORD_BITS-1:0] prev_i,
  input  logic [WORD_BITS-1:0] next_i,
  input  logic [WORD_BITS-1:0] load_i,
  output logic [WORD_BITS-1:0] q_o
);

  logic [WORD_BITS-1:0] word_r;

  always_ff @(posedge clk) begin
    case (sel)
      SEL_PREV: word_r <= prev_i;
      SEL_NEXT: word_r <= next_i;
      SEL_LOAD: word_r <= load_i;
      default:  word_r <= word_r;
    endcase
  end

  assign q_o = word_r;

endmodule
